// ===== sv/vn_pkg.sv =====
// ----------------------------------------------------------------------------
// vn_pkg: shared types and constants for the vector normalizer
// ----------------------------------------------------------------------------
package vn_pkg;

    localparam int FracBits   = 16;
    localparam int CompWidth  = 32;
    localparam int UnitWidth  = FracBits + 2;
    localparam int LenWidth   = 33;
    localparam int SumWidth   = 65;
    localparam int NumLanes   = 4;

    localparam logic [1:0] MODE_2D = 2'd0;
    localparam logic [1:0] MODE_3D = 2'd1;

    // per-item side data traveling with the lanes
    typedef struct packed {
        logic [NumLanes-1:0] used;
    } t_lane_ctl;

endpackage

// ===== sv/vn_sqrt.sv =====
// ----------------------------------------------------------------------------
// vn_sqrt: pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module vn_sqrt #(
    parameter int PassWidth = 1
) (
    input  logic                          i_clk,
    input  logic [vn_pkg::SumWidth-1:0]   i_rad,
    input  logic [PassWidth-1:0]          i_pass,
    output logic [vn_pkg::LenWidth-1:0]   o_root,
    output logic [PassWidth-1:0]          o_pass
);
    import vn_pkg::*;

    localparam int Steps = LenWidth;
    localparam int RadW  = 2 * Steps;
    localparam int RemW  = LenWidth + 2;

    logic [RadW-1:0]      r_rad  [Steps];
    logic [RemW-1:0]      r_rem  [Steps];
    logic [LenWidth-1:0]  r_root [Steps];
    logic [PassWidth-1:0] r_pass [Steps];

    // restoring root: bring down two radicand bits per stage
    for (genvar s = 0; s < Steps; s++) begin : g_step
        logic [RadW-1:0]      n_rad;
        logic [RemW-1:0]      n_rem;
        logic [LenWidth-1:0]  n_root;
        logic [PassWidth-1:0] n_pin;
        logic [RemW-1:0]      n_trial;
        logic [RemW-1:0]      n_cur;
        if (s == 0) begin : g_first
            // radicand padded to an even bit count
            assign n_rad  = {1'b0, i_rad};
            assign n_rem  = '0;
            assign n_root = '0;
            assign n_pin  = i_pass;
        end else begin : g_next
            assign n_rad  = r_rad[s-1];
            assign n_rem  = r_rem[s-1];
            assign n_root = r_root[s-1];
            assign n_pin  = r_pass[s-1];
        end
        always_comb begin
            n_cur   = {n_rem[RemW-3:0], n_rad[RadW-1 -: 2]};
            n_trial = {n_root[LenWidth-2:0], 2'b01};
        end
        always_ff @(posedge i_clk) begin
            r_rad[s]  <= {n_rad[RadW-3:0], 2'b00};
            r_pass[s] <= n_pin;
            if (n_cur >= n_trial) begin
                r_rem[s]  <= n_cur - n_trial;
                r_root[s] <= {n_root[LenWidth-2:0], 1'b1};
            end else begin
                r_rem[s]  <= n_cur;
                r_root[s] <= {n_root[LenWidth-2:0], 1'b0};
            end
        end
    end

    assign o_root = r_root[Steps-1];
    assign o_pass = r_pass[Steps-1];

endmodule

// ===== sv/vn_lane.sv =====
// ----------------------------------------------------------------------------
// vn_lane: one component lane, pipelined radix-2 divide and rounding
// ----------------------------------------------------------------------------
module vn_lane (
    input  logic                                 i_clk,
    input  logic [vn_pkg::CompWidth-1:0]         i_mag,
    input  logic                                 i_neg,
    input  logic                                 i_used,
    input  logic [vn_pkg::LenWidth-1:0]          i_len,
    output logic [vn_pkg::UnitWidth-1:0]         o_unit
);
    import vn_pkg::*;

    // quotient of (a<<F + len/2) / len is at most below 2^(32+F+1)
    localparam int NumW  = CompWidth + FracBits + 1;
    localparam int RemW  = LenWidth + 1;
    localparam logic [NumW-1:0] Lim = NumW'(1) << FracBits;

    logic [NumW-1:0]     r_num [NumW];
    logic [RemW-1:0]     r_rem [NumW];
    logic [LenWidth-1:0] r_den [NumW];
    logic                r_neg [NumW];
    logic                r_use [NumW];

    // one quotient bit per stage, quotient shifts into r_num
    for (genvar s = 0; s < NumW; s++) begin : g_div
        logic [NumW-1:0]     n_num;
        logic [RemW-1:0]     n_rem;
        logic [LenWidth-1:0] n_den;
        logic                n_neg;
        logic                n_use;
        logic [RemW-1:0]     n_cur;
        if (s == 0) begin : g_first
            assign n_num = ({{(FracBits+1){1'b0}}, i_mag} << FracBits) +
                           NumW'(i_len >> 1);
            assign n_rem = '0;
            assign n_den = i_len;
            assign n_neg = i_neg;
            assign n_use = i_used && (i_len != '0);
        end else begin : g_next
            assign n_num = r_num[s-1];
            assign n_rem = r_rem[s-1];
            assign n_den = r_den[s-1];
            assign n_neg = r_neg[s-1];
            assign n_use = r_use[s-1];
        end
        always_comb n_cur = {n_rem[RemW-2:0], n_num[NumW-1]};
        always_ff @(posedge i_clk) begin
            r_den[s] <= n_den;
            r_neg[s] <= n_neg;
            r_use[s] <= n_use;
            if (n_cur >= {1'b0, n_den}) begin
                r_rem[s] <= n_cur - {1'b0, n_den};
                r_num[s] <= {n_num[NumW-2:0], 1'b1};
            end else begin
                r_rem[s] <= n_cur;
                r_num[s] <= {n_num[NumW-2:0], 1'b0};
            end
        end
    end

    // saturate, restore sign, blank unused lanes and lanes with a zero length
    logic [NumW-1:0] n_q;
    always_comb begin
        n_q = (r_num[NumW-1] > Lim) ? Lim : r_num[NumW-1];
        if (!r_use[NumW-1])
            o_unit = '0;
        else if (r_neg[NumW-1])
            o_unit = UnitWidth'(-n_q);
        else
            o_unit = UnitWidth'(n_q);
    end

endmodule

// ===== sv/vn_merge.sv =====
// ----------------------------------------------------------------------------
// vn_merge: squares of the lanes and registered adder tree to the sum
// ----------------------------------------------------------------------------
module vn_merge (
    input  logic                                        i_clk,
    input  logic [vn_pkg::NumLanes-1:0][vn_pkg::CompWidth-1:0] i_mag,
    input  logic [vn_pkg::NumLanes-1:0]                 i_used,
    output logic [vn_pkg::SumWidth-1:0]                 o_sum
);
    import vn_pkg::*;

    logic [NumLanes-1:0][63:0] r_sq;
    logic [64:0] r_pair0;
    logic [64:0] r_pair1;

    // stage 1: one 32x32 multiply per lane
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NumLanes; k++) begin
            r_sq[k] <= i_used[k] ? 64'(i_mag[k]) * 64'(i_mag[k]) : 64'd0;
        end
    end

    // stage 2 and 3: two-level adder tree
    always_ff @(posedge i_clk) begin
        r_pair0 <= {1'b0, r_sq[0]} + {1'b0, r_sq[1]};
        r_pair1 <= {1'b0, r_sq[2]} + {1'b0, r_sq[3]};
        o_sum   <= r_pair0 + r_pair1;
    end

endmodule

// ===== sv/vector_normalize_top.sv =====
// ----------------------------------------------------------------------------
// vector_normalize_top: 2/3/4-component vector normalizer
// ----------------------------------------------------------------------------
// Usage: present a beat on the s_axis group; tdata carries mode and four
// signed components. One result beat per input beat leaves on m_axis with the
// unit vector (signed Q1.FRAC), the floored magnitude and a zero flag.
// Throughput: one beat per cycle while s_axis_tready is high. A beat passes
// the squares and adder tree, the pipelined root, the pipelined divider
// lanes and the output register, in that order.
// The pipeline never stops; finished beats collect in a 128-entry result
// fifo. A stall on m_axis_tready only fills that fifo, and s_axis_tready
// drops once the beats stored plus the beats in flight reach 126.
// Reset clears the valid pipeline and the fifo pointers and holds
// s_axis_tready low; data registers are not reset.
// ----------------------------------------------------------------------------
module vector_normalize_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // mode[1:0], comp_x[33:2], comp_y[65:34], comp_z[97:66], comp_w[129:98]
    input  logic [135:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // unit_x[17:0], unit_y[35:18], unit_z[53:36], unit_w[71:54],
    // length[104:72], zero_vector[105]
    output logic [111:0] m_axis_tdata
);
    import vn_pkg::*;

    localparam int SqLat  = 3;
    localparam int RtLat  = LenWidth;
    localparam int DivLat = CompWidth + FracBits + 1;
    localparam int Lat    = SqLat + RtLat + DivLat;

    // valid bit for each beat as it moves through the pipeline
    logic [Lat-1:0] r_vld;
    logic [1:0]     n_mode;
    logic [NumLanes-1:0][CompWidth-1:0] n_mag;
    logic [NumLanes-1:0] n_neg;
    t_lane_ctl      n_ctl;

    // unpack beat and take magnitudes
    always_comb begin
        n_mode = s_axis_tdata[1:0];
        for (int k = 0; k < NumLanes; k++) begin
            n_neg[k] = s_axis_tdata[2 + CompWidth*k + CompWidth-1];
            n_mag[k] = n_neg[k] ? CompWidth'(-s_axis_tdata[2 + CompWidth*k +: CompWidth])
                                : s_axis_tdata[2 + CompWidth*k +: CompWidth];
        end
        n_ctl.used[0] = 1'b1;
        n_ctl.used[1] = 1'b1;
        n_ctl.used[2] = (n_mode != MODE_2D);
        n_ctl.used[3] = (n_mode != MODE_2D) && (n_mode != MODE_3D);
    end

    // item data delayed alongside square/root stages
    localparam int PassW = NumLanes*CompWidth + NumLanes + NumLanes;
    logic [PassW-1:0] r_dl [SqLat];
    logic [SumWidth-1:0] n_sum;
    logic [LenWidth-1:0] n_root;
    logic [PassW-1:0]    n_pass;

    always_ff @(posedge i_clk) begin
        r_dl[0] <= {n_mag, n_neg, n_ctl.used};
        for (int k = 1; k < SqLat; k++) r_dl[k] <= r_dl[k-1];
    end

    vn_merge u_merge (
        .i_clk  (i_clk),
        .i_mag  (n_mag),
        .i_used (n_ctl.used),
        .o_sum  (n_sum)
    );

    vn_sqrt #(.PassWidth(PassW)) u_sqrt (
        .i_clk  (i_clk),
        .i_rad  (n_sum),
        .i_pass (r_dl[SqLat-1]),
        .o_root (n_root),
        .o_pass (n_pass)
    );

    logic [NumLanes-1:0][UnitWidth-1:0] n_unit;
    logic [LenWidth-1:0] r_len [DivLat];

    always_ff @(posedge i_clk) begin
        r_len[0] <= n_root;
        for (int k = 1; k < DivLat; k++) r_len[k] <= r_len[k-1];
    end

    for (genvar g = 0; g < NumLanes; g++) begin : g_lane
        vn_lane u_lane (
            .i_clk  (i_clk),
            .i_mag  (n_pass[PassW-1-CompWidth*(NumLanes-1-g) -: CompWidth]),
            .i_neg  (n_pass[NumLanes + g]),
            .i_used (n_pass[g]),
            .i_len  (n_root),
            .o_unit (n_unit[g])
        );
    end

    // result fifo absorbs everything in flight, so input only needs credit
    localparam int Depth = 128;
    localparam int AW    = $clog2(Depth);
    logic [105:0]  r_mem [Depth];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic [7:0]    r_inflight;
    logic          n_push, n_pop, n_acc;
    logic [105:0]  r_out;
    logic          r_ovld;

    assign n_acc  = s_axis_tvalid && s_axis_tready;
    assign n_push = r_vld[Lat-1];
    assign n_pop  = (r_cnt != '0) && (!r_ovld || m_axis_tready);
    assign s_axis_tready = i_rst_n && ((32'(r_cnt) + 32'(r_inflight)) < (Depth - 2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_wp       <= '0;
            r_rp       <= '0;
            r_cnt      <= '0;
            r_inflight <= '0;
            r_ovld     <= 1'b0;
        end else begin
            r_vld <= {r_vld[Lat-2:0], n_acc};
            r_inflight <= r_inflight + 8'(n_acc) - 8'(n_push);
            if (n_push) r_wp <= r_wp + 1'b1;
            if (n_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(n_push) - (AW+1)'(n_pop);
            if (n_pop) r_ovld <= 1'b1;
            else if (m_axis_tready) r_ovld <= 1'b0;
        end
    end

    // fifo storage and registered read
    always_ff @(posedge i_clk) begin
        if (n_push)
            r_mem[r_wp] <= {(r_len[DivLat-1] == '0), r_len[DivLat-1],
                            n_unit[3], n_unit[2], n_unit[1], n_unit[0]};
        if (n_pop) r_out <= r_mem[r_rp];
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {6'd0, r_out};

endmodule

// ===== dv/vector_normalize_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_normalize_top_tb: self-checking bench for the vector normalizer
// ----------------------------------------------------------------------------
// Drives vector beats (2d, 3d, 4d and the reserved mode) with random gaps,
// predicts each unit vector, magnitude and zero flag in the bench, and checks
// every output beat in order. One phase holds the output off for a long
// stretch so the pipeline fills and stalls its input.
// ----------------------------------------------------------------------------
module vector_normalize_top_tb;

    import vn_pkg::*;

    localparam int Latency   = 3 + 33 + (33 + FracBits) + 1;
    localparam int CycleCap  = 400000;
    localparam logic [1:0] MODE_4D  = 2'd2;
    localparam logic [1:0] MODE_RSV = 2'd3;

    typedef struct packed {
        logic [5:0]           pad;
        logic                 zero_vector;
        logic [LenWidth-1:0]  length;
        logic [UnitWidth-1:0] unit_w;
        logic [UnitWidth-1:0] unit_z;
        logic [UnitWidth-1:0] unit_y;
        logic [UnitWidth-1:0] unit_x;
    } t_norm_res;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // mode[1:0], comp_x[33:2], comp_y[65:34], comp_z[97:66], comp_w[129:98]
    logic [135:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // unit_x[17:0], unit_y[35:18], unit_z[53:36], unit_w[71:54],
    // length[104:72], zero_vector[105]
    logic [111:0] m_axis_tdata;

    t_norm_res norm_queue[$];
    int        mismatches = 0;
    int        cycle_cnt  = 0;
    bit        long_hold  = 1'b0;

    vector_normalize_top u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CycleCap) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // floor square root of a 65-bit sum
    function automatic logic [LenWidth-1:0] isqrt(logic [64:0] n);
        logic [64:0] r;
        r = 0;
        for (int b = 32; b >= 0; b--) begin
            logic [66:0] c;
            c = {2'b00, r} | (67'd1 << b);
            if (c * c <= {2'b00, n}) r = c[64:0];
        end
        return r[LenWidth-1:0];
    endfunction

    function automatic logic [UnitWidth-1:0] scale_comp(logic [31:0] c,
                                                        logic [LenWidth-1:0] len);
        logic [63:0] mag, quo;
        mag = c[31] ? {32'd0, -c} : {32'd0, c};
        quo = ((mag << FracBits) + (len >> 1)) / len;
        if (quo > (64'd1 << FracBits)) quo = 64'd1 << FracBits;
        if (c[31]) quo = -quo;
        return quo[UnitWidth-1:0];
    endfunction

    function automatic t_norm_res predict_norm(logic [1:0] mode, logic [31:0] comps[4]);
        t_norm_res   r;
        int          used;
        logic [64:0] sum;
        logic [63:0] mag;
        r = '0;
        used = (mode == MODE_2D) ? 2 : (mode == MODE_3D) ? 3 : 4;
        sum = 0;
        for (int i = 0; i < used; i++) begin
            mag = comps[i][31] ? {32'd0, -comps[i]} : {32'd0, comps[i]};
            sum += mag * mag;
        end
        r.length = isqrt(sum);
        r.zero_vector = (r.length == 0);
        if (r.length != 0) begin
            r.unit_x = scale_comp(comps[0], r.length);
            r.unit_y = scale_comp(comps[1], r.length);
            if (used > 2) r.unit_z = scale_comp(comps[2], r.length);
            if (used > 3) r.unit_w = scale_comp(comps[3], r.length);
        end
        return r;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // send one vector beat and queue its expected result
    task automatic send_vector(logic [1:0] mode, logic [31:0] x, logic [31:0] y,
                               logic [31:0] z, logic [31:0] w, bit gaps = 1);
        logic [31:0] comps[4];
        int          g;
        comps = '{x, y, z, w};
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, w, z, y, x, mode};
        norm_queue.push_back(predict_norm(mode, comps));
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic idle_input();
        s_axis_tvalid <= 1'b0;
    endtask

    // output side: random stalls, or a long hold when asked
    always @(posedge i_clk) begin
        if (!i_rst_n || long_hold) m_axis_tready <= 1'b0;
        else if ($urandom_range(0, 99) < 8) m_axis_tready <= 1'b0;
        else if ($urandom_range(0, 99) < 30) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_norm_res got, want;
            got = m_axis_tdata;
            if (norm_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", m_axis_tdata);
            end else begin
                want = norm_queue.pop_front();
                if (got.unit_x !== want.unit_x || got.unit_y !== want.unit_y ||
                    got.unit_z !== want.unit_z || got.unit_w !== want.unit_w ||
                    got.length !== want.length ||
                    got.zero_vector !== want.zero_vector) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp x%h y%h z%h w%h len%h z%b got x%h y%h z%h w%h len%h z%b",
                                 want.unit_x, want.unit_y, want.unit_z, want.unit_w,
                                 want.length, want.zero_vector, got.unit_x, got.unit_y,
                                 got.unit_z, got.unit_w, got.length, got.zero_vector);
                end
            end
        end
    end

    task automatic test_directed();
        logic [31:0] mn, mx;
        mn = 32'h8000_0000;
        mx = 32'h7fff_ffff;
        send_vector(MODE_2D, 0, 0, 5, 5);
        send_vector(MODE_3D, 0, 0, 0, 7);
        send_vector(MODE_4D, 0, 0, 0, 0);
        send_vector(MODE_4D, mn, mn, mn, mn);
        send_vector(MODE_RSV, mn, mn, mn, mn);
        send_vector(MODE_4D, mx, mx, mx, mx);
        send_vector(MODE_2D, mn, mx, 1, 1);
        send_vector(MODE_3D, mx, mn, mx, 0);
        send_vector(MODE_2D, 32'h0001_0000, 0, 0, 0);
        send_vector(MODE_2D, 32'hffff_0000, 0, 0, 0);
        send_vector(MODE_2D, 1, 0, 0, 0);
        send_vector(MODE_2D, 1, 1, 0, 0);
        send_vector(MODE_3D, 1, 1, 1, 0);
        send_vector(MODE_4D, 32'hffff_ffff, 1, 32'hffff_ffff, 1);
        send_vector(MODE_2D, 3, 4, 0, 0);
        send_vector(MODE_RSV, 0, 0, 0, 9);
        send_vector(MODE_3D, 0, 0, mn, 0);
        send_vector(MODE_4D, 2, 3, 5, 7);
        idle_input();
    endtask

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 15) - 8;
            1: return $urandom_range(0, 32'h0003_0000) - 32'h0001_8000;
            2: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'h0} | $urandom_range(0, 3);
            default: return $urandom();
        endcase
    endfunction

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_vector(2'($urandom_range(0, 3)), rand_comp(), rand_comp(),
                        rand_comp(), rand_comp());
        idle_input();
    endtask

    // hold the output off while the input keeps offering beats
    task automatic test_backpressure();
        long_hold = 1'b1;
        fork
            begin
                repeat (Latency + 150) @(posedge i_clk);
                long_hold = 1'b0;
            end
            for (int i = 0; i < 200; i++)
                send_vector(2'($urandom_range(0, 3)), $urandom(), $urandom(),
                            $urandom(), $urandom(), 0);
        join
        idle_input();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(350);
        test_backpressure();
        test_random(380);
        while (norm_queue.size() != 0) @(posedge i_clk);
        repeat (Latency + 20) @(posedge i_clk);
        if (mismatches == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule
